@@ src/pkn_pkg.sv @@
// Shared constants, status codes and code tables of the pad and key net code codec.
`timescale 1ns / 1ps
`default_nettype none

package pkn_pkg;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_SIZE_ERR = 2'd2;
    localparam logic [1:0] ST_INACTIVE = 2'd3;

    // Key codes carried in the low seven bits of code byte 0
    localparam logic [6:0] CODE_EXEC     = 7'd127;
    localparam logic [6:0] CODE_CANCEL   = 7'd126;
    localparam logic [6:0] CODE_PAUSE    = 7'd125;
    localparam logic [6:0] CODE_KEY_BASE = 7'd36;

    // Idle code sent when no local input is encoded
    localparam logic [7:0] TX0_IDLE = 8'h83;
    localparam logic [7:0] TX1_IDLE = 8'hff;

    // Row masks for keys that travel in code byte 1 or in bit 7 of code byte 0
    localparam logic [7:0] ROW6_SENT_MASK = 8'h17;
    localparam logic [7:0] ROW8_SENT_MASK = 8'hf1;
    localparam logic [7:0] ROW6_FILL      = 8'he8;
    localparam logic [7:0] ROW8_FILL      = 8'h0e;

    // Released states
    localparam logic [7:0] ROW_IDLE = 8'hff;
    localparam logic [5:0] JOY_IDLE = 6'h3f;

    // Keyboard geometry
    localparam int unsigned NUM_ROWS    = 12;
    localparam int unsigned SCAN_ROWS   = 11;
    localparam int unsigned ROW_W       = 8;
    localparam int unsigned ROWS_W      = NUM_ROWS * ROW_W;
    localparam int unsigned EXEC_BIT    = 11 * ROW_W + 1;
    localparam int unsigned CANCEL_BIT  = 11 * ROW_W + 3;

    // Valid receive sizes
    localparam logic [7:0] SIZE_MIN = 8'd2;
    localparam logic [7:0] SIZE_MAX = 8'd16;

    // Joystick direction bits to net direction code
    function automatic logic [5:0] dir_to_net(input logic [3:0] dir);
        logic [5:0] code;
        case (dir)
            4'h0:    code = 6'd24;
            4'h1:    code = 6'd24;
            4'h2:    code = 6'd32;
            4'h3:    code = 6'd28;
            4'h4:    code = 6'd8;
            4'h5:    code = 6'd16;
            4'h6:    code = 6'd8;
            4'h7:    code = 6'd12;
            4'h8:    code = 6'd32;
            4'h9:    code = 6'd24;
            4'ha:    code = 6'd32;
            4'hb:    code = 6'd28;
            4'hc:    code = 6'd4;
            4'hd:    code = 6'd20;
            4'he:    code = 6'd4;
            default: code = 6'd0;
        endcase
        return code;
    endfunction

    // Net direction code back to joystick direction bits
    function automatic logic [3:0] net_to_dir(input logic [3:0] code);
        logic [3:0] dir;
        case (code)
            4'h0:    dir = 4'hf;
            4'h1:    dir = 4'he;
            4'h2:    dir = 4'h6;
            4'h3:    dir = 4'h7;
            4'h4:    dir = 4'h5;
            4'h5:    dir = 4'hd;
            4'h6:    dir = 4'h9;
            4'h7:    dir = 4'hb;
            4'h8:    dir = 4'ha;
            default: dir = 4'hf;
        endcase
        return dir;
    endfunction

endpackage

`default_nettype wire

@@ src/pad_key_netcode_codec.sv @@
// Top level of the pad and key net code codec: three-stage pipeline and register port.
//
//  Channel   | Direction | Handshake              | Content
//  ----------+-----------+------------------------+------------------------------------
//  s_*       | in        | s_tvalid / s_tready    | one frame of local and received input
//  m_*       | out       | m_tvalid / m_tready    | sent code, merged keys, pads, status
//  APB       | in/out    | psel, penable, pready  | session_active, local_player,
//            |           |                        | kbd_send at 0x0, 0x4, 0x8
//
// An accepted frame request moves from the stage 1 register through the stage 2 register
// into the result register; unless the output stalls, one request may enter in every
// cycle. Each stage holds its own valid bit and moves on when the stage after it is empty
// or moving, so gaps close up; once all three stages are full a waiting result holds the
// input. Reset (rst_n low) empties the pipeline and loads the registers with session off,
// player 1 and keyboard on. APB writes are meant to come while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pad_key_netcode_codec
    import pkn_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [63:0] key_rows_low, [95:64] key_rows_high, [101:96] local_joy1,
    // [107:102] local_joy2, [108] pause_pressed, [116:109] rx_p1_byte0,
    // [124:117] rx_p1_byte1, [132:125] rx_p2_byte0, [140:133] rx_p2_byte1,
    // [148:141] rx_size, [151:149] zero
    input  wire logic [151:0] s_tdata,
    // Output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] tx_byte0, [15:8] tx_byte1, [79:16] key_rows_low_out,
    // [111:80] key_rows_high_out, [117:112] joy1_out, [123:118] joy2_out,
    // [124] pause_out, [126:125] frame_status, [127] zero
    output logic [127:0]      m_tdata,
    // Register port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register byte addresses
    localparam logic [3:0] ADDR_SESSION  = 4'h0;
    localparam logic [3:0] ADDR_PLAYER   = 4'h4;
    localparam logic [3:0] ADDR_KEYBOARD = 4'h8;

    // What a received code byte 0 asks for
    typedef enum logic [2:0] {
        RX_JOY,
        RX_EXEC,
        RX_CANCEL,
        RX_PAUSE,
        RX_KEY
    } rx_kind_t;

    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic [5:0]        joy1;
        logic [5:0]        joy2;
        logic              pause;
        logic [1:0]        status;
        logic              tx_active;
        logic [7:0]        tx0_base;
        logic [7:0]        tx1_kb;
        logic              kb_exec;
        logic              kb_cancel;
        rx_kind_t          kind_a;
        rx_kind_t          kind_b;
        logic [5:0]        joy_a;
        logic [5:0]        joy_b;
        logic [6:0]        key_a;
        logic [6:0]        key_b;
        logic [7:0]        m_row6;
        logic [7:0]        m_row8;
    } stage1_t;

    typedef struct packed {
        logic [ROWS_W-1:0]                rows;
        logic [5:0]                       joy1;
        logic [5:0]                       joy2;
        logic                             pause;
        logic [1:0]                       status;
        logic                             tx_active;
        logic [7:0]                       tx0_base;
        logic [7:0]                       tx1_kb;
        logic                             kb_exec;
        logic                             kb_cancel;
        logic [SCAN_ROWS-1:0]             row_hit;
        logic [SCAN_ROWS-1:0][2:0]        row_bit;
        logic [ROWS_W-1:0]                press;
        logic [5:0]                       dec_joy1;
        logic [5:0]                       dec_joy2;
        logic                             dec_pause;
        logic [7:0]                       m_row6;
        logic [7:0]                       m_row8;
    } stage2_t;

    typedef struct packed {
        logic [1:0]        frame_status;
        logic              pause_out;
        logic [5:0]        joy2_out;
        logic [5:0]        joy1_out;
        logic [31:0]       key_rows_high_out;
        logic [63:0]       key_rows_low_out;
        logic [7:0]        tx_byte1;
        logic [7:0]        tx_byte0;
    } result_t;

    logic       session_active_reg;
    logic [3:0] local_player_reg;
    logic       kbd_send_reg;

    logic    v1_reg, v2_reg, v3_reg;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t s3_reg, s3_next;
    logic    en1, en2, en3;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_active_reg <= 1'b0;
            local_player_reg   <= 4'd1;
            kbd_send_reg       <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_SESSION:  session_active_reg <= pwdata[0];
                ADDR_PLAYER:   local_player_reg   <= pwdata[3:0];
                ADDR_KEYBOARD: kbd_send_reg       <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr)
            ADDR_SESSION:  prdata = {31'd0, session_active_reg};
            ADDR_PLAYER:   prdata = {28'd0, local_player_reg};
            ADDR_KEYBOARD: prdata = {31'd0, kbd_send_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // Stage advance: each stage moves when the one after it is free
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, s3_reg};

    function automatic rx_kind_t rx_kind(input logic [6:0] v);
        rx_kind_t k;
        if (v < CODE_KEY_BASE)
            k = RX_JOY;
        else if (v == CODE_EXEC)
            k = RX_EXEC;
        else if (v == CODE_CANCEL)
            k = RX_CANCEL;
        else if (v == CODE_PAUSE)
            k = RX_PAUSE;
        else
            k = RX_KEY;
        return k;
    endfunction

    // Stage 1: unpack the request, build the local code parts and classify received codes
    always_comb
    begin
        logic [7:0] a0, a1, b0, b1, m0, m1, sz, row6, row8, row11;
        logic [5:0] joy1;
        a0    = s_tdata[116:109];
        a1    = s_tdata[124:117];
        b0    = s_tdata[132:125];
        b1    = s_tdata[140:133];
        sz    = s_tdata[148:141];
        joy1  = s_tdata[101:96];
        row6  = s_tdata[55:48];
        row8  = s_tdata[71:64];
        row11 = s_tdata[95:88];
        m0    = a0 & b0;
        m1    = a1 & b1;

        s1_next.rows  = s_tdata[95:0];
        s1_next.joy1  = joy1;
        s1_next.joy2  = s_tdata[107:102];
        s1_next.pause = s_tdata[108];

        if (!session_active_reg)
            s1_next.status = ST_INACTIVE;
        else if (sz == 8'd0)
            s1_next.status = ST_EMPTY;
        else if (sz < SIZE_MIN || sz > SIZE_MAX)
            s1_next.status = ST_SIZE_ERR;
        else
            s1_next.status = ST_OK;

        s1_next.tx_active = session_active_reg &&
                            (local_player_reg == 4'd1 || local_player_reg == 4'd2);
        s1_next.tx0_base  = {row6[4], 1'b0, dir_to_net(joy1[3:0]) | {4'd0, joy1[5:4]}};
        s1_next.tx1_kb    = {row8[7:4], row6[2:0], row8[0]};
        s1_next.kb_exec   = !row11[1];
        s1_next.kb_cancel = !row11[3];

        s1_next.kind_a = rx_kind(a0[6:0]);
        s1_next.kind_b = rx_kind(b0[6:0]);
        s1_next.joy_a  = {a0[1:0], net_to_dir(a0[5:2])};
        s1_next.joy_b  = {b0[1:0], net_to_dir(b0[5:2])};
        s1_next.key_a  = a0[6:0] - CODE_KEY_BASE;
        s1_next.key_b  = b0[6:0] - CODE_KEY_BASE;
        s1_next.m_row8 = m1 | ROW8_FILL;
        s1_next.m_row6 = {3'b000, m0[7], 1'b0, m1[3:1]} | ROW6_FILL;
    end

    // Key matrix bit that one received code presses
    function automatic logic [ROWS_W-1:0] press_mask(input rx_kind_t k, input logic [6:0] key);
        logic [ROWS_W-1:0] m;
        m = '0;
        case (k)
            RX_EXEC:   m[EXEC_BIT]   = 1'b1;
            RX_CANCEL: m[CANCEL_BIT] = 1'b1;
            RX_KEY:    m[key]        = 1'b1;
            default:   m = '0;
        endcase
        return m;
    endfunction

    // Stage 2: scan each local row 0 to 10 for its first pressed key and expand received codes
    always_comb
    begin
        logic [SCAN_ROWS-1:0][7:0] ck;
        for (int r = 0; r < SCAN_ROWS; r++)
        begin
            ck[r] = s1_reg.rows[r*ROW_W +: ROW_W];
        end
        ck[6] = ck[6] | ROW6_SENT_MASK;
        ck[8] = ck[8] | ROW8_SENT_MASK;

        s2_next.rows      = s1_reg.rows;
        s2_next.joy1      = s1_reg.joy1;
        s2_next.joy2      = s1_reg.joy2;
        s2_next.pause     = s1_reg.pause;
        s2_next.status    = s1_reg.status;
        s2_next.tx_active = s1_reg.tx_active;
        s2_next.tx0_base  = s1_reg.tx0_base;
        s2_next.tx1_kb    = s1_reg.tx1_kb;
        s2_next.kb_exec   = s1_reg.kb_exec;
        s2_next.kb_cancel = s1_reg.kb_cancel;
        s2_next.m_row6    = s1_reg.m_row6;
        s2_next.m_row8    = s1_reg.m_row8;

        for (int r = 0; r < SCAN_ROWS; r++)
        begin
            s2_next.row_hit[r] = (ck[r] != ROW_IDLE);
            s2_next.row_bit[r] = 3'd0;
            for (int j = ROW_W - 1; j >= 0; j--)
            begin
                if (!ck[r][j])
                    s2_next.row_bit[r] = 3'(j);
            end
        end

        s2_next.press     = press_mask(s1_reg.kind_a, s1_reg.key_a) |
                            press_mask(s1_reg.kind_b, s1_reg.key_b);
        s2_next.dec_joy1  = (s1_reg.kind_a == RX_JOY) ? s1_reg.joy_a : JOY_IDLE;
        s2_next.dec_joy2  = (s1_reg.kind_b == RX_JOY) ? s1_reg.joy_b : JOY_IDLE;
        s2_next.dec_pause = (s1_reg.kind_a == RX_PAUSE) || (s1_reg.kind_b == RX_PAUSE);
    end

    // Stage 3: pick the sent key code and assemble the result
    always_comb
    begin
        logic [6:0]        key_code;
        logic              key_found;
        logic [ROWS_W-1:0] dec_rows;
        logic [ROWS_W-1:0] out_rows;

        // First row, counting up, that holds a pressed key
        key_found = 1'b0;
        key_code  = 7'd0;
        for (int r = SCAN_ROWS - 1; r >= 0; r--)
        begin
            if (s2_reg.row_hit[r])
            begin
                key_found = 1'b1;
                key_code  = CODE_KEY_BASE + {r[3:0], s2_reg.row_bit[r]};
            end
        end

        // Sent code bytes
        if (!s2_reg.tx_active)
        begin
            s3_next.tx_byte0 = TX0_IDLE;
            s3_next.tx_byte1 = TX1_IDLE;
        end
        else if (!kbd_send_reg)
        begin
            s3_next.tx_byte0 = s2_reg.tx0_base | 8'h80;
            s3_next.tx_byte1 = TX1_IDLE;
        end
        else
        begin
            s3_next.tx_byte1 = s2_reg.tx1_kb;
            if (s2_reg.kb_exec)
                s3_next.tx_byte0 = {s2_reg.tx0_base[7], CODE_EXEC};
            else if (s2_reg.kb_cancel)
                s3_next.tx_byte0 = {s2_reg.tx0_base[7], CODE_CANCEL};
            else if (s2_reg.pause)
                s3_next.tx_byte0 = {s2_reg.tx0_base[7], CODE_PAUSE};
            else if (key_found)
                s3_next.tx_byte0 = {s2_reg.tx0_base[7], key_code};
            else
                s3_next.tx_byte0 = s2_reg.tx0_base;
        end

        // Merged matrix from the received codes
        dec_rows = {ROW_IDLE, ROW_IDLE, ROW_IDLE, s2_reg.m_row8, ROW_IDLE, s2_reg.m_row6,
                    {6{ROW_IDLE}}} & ~s2_reg.press;

        case (s2_reg.status)
            ST_OK:
            begin
                out_rows           = dec_rows;
                s3_next.joy1_out   = s2_reg.dec_joy1;
                s3_next.joy2_out   = s2_reg.dec_joy2;
                s3_next.pause_out  = s2_reg.dec_pause;
            end
            ST_EMPTY:
            begin
                out_rows           = {NUM_ROWS{ROW_IDLE}};
                s3_next.joy1_out   = JOY_IDLE;
                s3_next.joy2_out   = JOY_IDLE;
                s3_next.pause_out  = 1'b0;
            end
            default:
            begin
                out_rows           = s2_reg.rows;
                s3_next.joy1_out   = s2_reg.joy1;
                s3_next.joy2_out   = s2_reg.joy2;
                s3_next.pause_out  = s2_reg.pause;
            end
        endcase

        s3_next.key_rows_low_out  = out_rows[63:0];
        s3_next.key_rows_high_out = out_rows[95:64];
        s3_next.frame_status      = s2_reg.status;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
            s1_reg <= s1_next;
        if (en2 && v1_reg)
            s2_reg <= s2_next;
        if (en3 && v2_reg)
            s3_reg <= s3_next;
    end

endmodule

`default_nettype wire
